>>> rtl/cwm_pkg.sv
// ----------------------------------------------------------------------------
// cwm_pkg
// Shared types and constants for the click-wheel menu controller.
// ----------------------------------------------------------------------------
package cwm_pkg;

  localparam int unsigned SEGMENTS       = 12;
  localparam int unsigned SEG_W          = 4;
  localparam int unsigned ITEM_W         = 8;
  localparam int unsigned VOL_W          = 8;
  localparam int unsigned SCREEN_W       = 2;

  localparam logic [SEG_W-1:0] WRAP_HIGH_FIRST = 4'd8;
  localparam logic [SEG_W-1:0] WRAP_HIGH_LAST  = 4'd11;
  localparam logic [SEG_W-1:0] WRAP_LOW_LAST   = 4'd4;
  localparam logic [SEG_W-1:0] SEG_LIMIT       = SEG_W'(SEGMENTS);

  localparam logic [SCREEN_W-1:0] SCR_HOME    = 2'd0;
  localparam logic [SCREEN_W-1:0] SCR_LIST    = 2'd1;
  localparam logic [SCREEN_W-1:0] SCR_PLAYING = 2'd2;

  localparam logic CFG_MAX_ITEM = 1'b0;
  localparam logic CFG_VOL_MAX  = 1'b1;

  localparam logic [ITEM_W-1:0] MAX_ITEM_RST = 8'd2;
  localparam logic [VOL_W-1:0]  VOL_MAX_RST  = 8'd255;

  typedef struct packed {
    logic [ITEM_W-1:0] max_item;
    logic [VOL_W-1:0]  vol_max;
  } cfg_t;

  typedef struct packed {
    logic             wheel_touched;
    logic [SEG_W-1:0] wheel_segment;
    logic             menu_btn;
    logic             ff_btn;
    logic             rw_btn;
    logic             pp_btn;
    logic             select_btn;
  } item_in_t;

  typedef struct packed {
    logic menu;
    logic ff;
    logic rw;
    logic sel;
  } held_t;

  typedef struct packed {
    logic [SEG_W-1:0]    last_segment;
    logic                wheel_was_touched;
    logic [ITEM_W-1:0]   item_index;
    logic [SCREEN_W-1:0] screen_mode;
    logic [VOL_W-1:0]    volume_level;
    held_t               held;
  } state_t;

  typedef struct packed {
    logic [ITEM_W-1:0]   selected_item;
    logic [SCREEN_W-1:0] screen;
    logic [VOL_W-1:0]    volume;
    logic                volume_changed;
    logic                clear_screen;
    logic                redraw;
    logic                stop_song;
    logic                start_play;
    logic                play_held;
  } result_t;

endpackage

>>> rtl/cwm_step.sv
// ----------------------------------------------------------------------------
// cwm_step
// Next-state and result logic for one sample of buttons and wheel.
// ----------------------------------------------------------------------------
module cwm_step (
  input  cwm_pkg::cfg_t     cfg,
  input  cwm_pkg::state_t   st,
  input  cwm_pkg::item_in_t din,
  output cwm_pkg::state_t   st_nxt,
  output cwm_pkg::result_t  res
);
  import cwm_pkg::*;

  localparam int unsigned IW = ITEM_W + 2;

  logic                menu_edge, ff_edge, rw_edge, sel_edge;
  logic [SCREEN_W-1:0] scr_menu, scr_sel;
  logic                item_zero_menu, item_zero_sel;
  logic                redraw_menu, redraw_sel, redraw_wheel;
  logic                stop, start;
  logic [VOL_W-1:0]    vol_ff, vol_rw;
  logic                seg_ok;
  logic [SEG_W-1:0]    ref_seg;
  logic                seg_hi, seg_lo, ref_hi, ref_lo;
  logic                step_up, step_dn;
  logic signed [IW-1:0] item_btn, item_wh, item_max;
  logic [ITEM_W-1:0]   item_fin;

  assign menu_edge = din.menu_btn   & ~st.held.menu;
  assign ff_edge   = din.ff_btn     & ~st.held.ff;
  assign rw_edge   = din.rw_btn     & ~st.held.rw;
  assign sel_edge  = din.select_btn & ~st.held.sel;

  // menu
  always_comb begin
    scr_menu       = st.screen_mode;
    item_zero_menu = 1'b0;
    redraw_menu    = 1'b0;
    stop           = 1'b0;
    if (menu_edge) begin
      case (st.screen_mode)
        SCR_LIST: begin
          scr_menu = SCR_HOME; item_zero_menu = 1'b1; redraw_menu = 1'b1;
        end
        SCR_PLAYING: begin
          scr_menu = SCR_LIST; item_zero_menu = 1'b1; redraw_menu = 1'b1;
          stop = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // volume: up first, then down
  assign vol_ff = (ff_edge && st.volume_level < cfg.vol_max) ?
                  st.volume_level + VOL_W'(1) : st.volume_level;
  assign vol_rw = (rw_edge && vol_ff != '0) ? vol_ff - VOL_W'(1) : vol_ff;

  // select
  always_comb begin
    scr_sel       = scr_menu;
    item_zero_sel = 1'b0;
    redraw_sel    = 1'b0;
    start         = 1'b0;
    if (sel_edge) begin
      case (scr_menu)
        SCR_HOME: begin
          if (item_zero_menu || st.item_index == '0) begin
            scr_sel = SCR_LIST; item_zero_sel = 1'b1; redraw_sel = 1'b1;
          end
        end
        SCR_LIST: begin
          scr_sel = SCR_PLAYING; item_zero_sel = 1'b1; redraw_sel = 1'b1;
          start = 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign item_btn = (item_zero_menu || item_zero_sel) ? '0 :
                    IW'($signed({2'b00, st.item_index}));

  // wheel
  assign seg_ok  = din.wheel_touched && (din.wheel_segment < SEG_LIMIT);
  assign ref_seg = st.wheel_was_touched ? st.last_segment : din.wheel_segment;
  assign seg_hi  = din.wheel_segment >= WRAP_HIGH_FIRST &&
                   din.wheel_segment <= WRAP_HIGH_LAST;
  assign seg_lo  = din.wheel_segment <= WRAP_LOW_LAST;
  assign ref_hi  = ref_seg >= WRAP_HIGH_FIRST && ref_seg <= WRAP_HIGH_LAST;
  assign ref_lo  = ref_seg <= WRAP_LOW_LAST;

  always_comb begin
    step_up = 1'b0;
    step_dn = 1'b0;
    if (seg_hi && ref_lo)                   step_dn = 1'b1;
    else if (seg_lo && ref_hi)              step_up = 1'b1;
    else if (din.wheel_segment > ref_seg)   step_up = 1'b1;
    else if (din.wheel_segment < ref_seg)   step_dn = 1'b1;
  end

  assign redraw_wheel = seg_ok && (!st.wheel_was_touched || step_up || step_dn);

  always_comb begin
    item_wh = item_btn;
    if (seg_ok && step_up) item_wh = item_btn + IW'(1);
    if (seg_ok && step_dn) item_wh = item_btn - IW'(1);
  end

  // clamp to 0..max_item
  assign item_max = IW'($signed({2'b00, cfg.max_item}));
  always_comb begin
    if (item_wh > item_max)      item_fin = cfg.max_item;
    else if (item_wh[IW-1])      item_fin = '0;
    else                         item_fin = item_wh[ITEM_W-1:0];
  end

  always_comb begin
    st_nxt                   = st;
    st_nxt.held.menu         = din.menu_btn;
    st_nxt.held.ff           = din.ff_btn;
    st_nxt.held.rw           = din.rw_btn;
    st_nxt.held.sel          = din.select_btn;
    st_nxt.screen_mode       = scr_sel;
    st_nxt.volume_level      = vol_rw;
    st_nxt.item_index        = item_fin;
    st_nxt.wheel_was_touched = seg_ok;
    if (seg_ok) st_nxt.last_segment = din.wheel_segment;
  end

  assign res.selected_item  = item_fin;
  assign res.screen         = scr_sel;
  assign res.volume         = vol_rw;
  assign res.volume_changed = ff_edge | rw_edge;
  assign res.clear_screen   = menu_edge | sel_edge;
  assign res.redraw         = redraw_menu | din.ff_btn | redraw_sel | redraw_wheel;
  assign res.stop_song      = stop;
  assign res.start_play     = start;
  assign res.play_held      = din.pp_btn;

endmodule

>>> rtl/click_wheel_menu_controller.sv
// ----------------------------------------------------------------------------
// click_wheel_menu_controller
// Menu, volume and touch-wheel navigation controller for a click-wheel UI.
// ----------------------------------------------------------------------------
// One result per input transfer, one transfer per cycle sustained while
// the result side is ready. An input register captures the sample, then
// the step logic updates menu state and fills the free result register.
// Configuration writes take effect at the next processed sample.
module click_wheel_menu_controller (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [cwm_pkg::ITEM_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_wheel_touched,
  input  logic [cwm_pkg::SEG_W-1:0]     in_wheel_segment,
  input  logic                          in_menu_btn,
  input  logic                          in_ff_btn,
  input  logic                          in_rw_btn,
  input  logic                          in_pp_btn,
  input  logic                          in_select_btn,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cwm_pkg::ITEM_W-1:0]    out_selected_item,
  output logic [cwm_pkg::SCREEN_W-1:0]  out_screen,
  output logic [cwm_pkg::VOL_W-1:0]     out_volume,
  output logic                          out_volume_changed,
  output logic                          out_clear_screen,
  output logic                          out_redraw,
  output logic                          out_stop_song,
  output logic                          out_start_play,
  output logic                          out_play_held
);
  import cwm_pkg::*;

  cfg_t     cfg_r;
  item_in_t in_r;
  logic     in_valid_r;
  state_t   st_r, st_nxt;
  result_t  res_nxt, res_r;
  logic     out_valid_r;
  logic     advance;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  cwm_step u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .din    (in_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_item <= MAX_ITEM_RST;
      cfg_r.vol_max  <= VOL_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_ITEM: cfg_r.max_item <= cfg_data;
        CFG_VOL_MAX:  cfg_r.vol_max  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r.wheel_touched <= in_wheel_touched;
      in_r.wheel_segment <= in_wheel_segment;
      in_r.menu_btn      <= in_menu_btn;
      in_r.ff_btn        <= in_ff_btn;
      in_r.rw_btn        <= in_rw_btn;
      in_r.pp_btn        <= in_pp_btn;
      in_r.select_btn    <= in_select_btn;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.last_segment      <= '0;
      st_r.wheel_was_touched <= 1'b1;
      st_r.item_index        <= '0;
      st_r.screen_mode       <= SCR_HOME;
      st_r.volume_level      <= '0;
      st_r.held              <= '0;
      out_valid_r            <= 1'b0;
    end else begin
      if (advance) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_selected_item  = res_r.selected_item;
  assign out_screen         = res_r.screen;
  assign out_volume         = res_r.volume;
  assign out_volume_changed = res_r.volume_changed;
  assign out_clear_screen   = res_r.clear_screen;
  assign out_redraw         = res_r.redraw;
  assign out_stop_song      = res_r.stop_song;
  assign out_start_play     = res_r.start_play;
  assign out_play_held      = res_r.play_held;

endmodule

>>> verif/cwm_menu_checker.sv
// ----------------------------------------------------------------------------
// cwm_menu_checker
// Watches the sample and result channels of the click-wheel menu controller.
// Keeps its own copy of the menu, volume and wheel state, predicts one result
// per accepted sample and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module cwm_menu_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cwm_pkg::cfg_t                cfg,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic                         in_wheel_touched,
  input  logic [cwm_pkg::SEG_W-1:0]    in_wheel_segment,
  input  logic                         in_menu_btn,
  input  logic                         in_ff_btn,
  input  logic                         in_rw_btn,
  input  logic                         in_pp_btn,
  input  logic                         in_select_btn,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [cwm_pkg::ITEM_W-1:0]   out_selected_item,
  input  logic [cwm_pkg::SCREEN_W-1:0] out_screen,
  input  logic [cwm_pkg::VOL_W-1:0]    out_volume,
  input  logic                         out_volume_changed,
  input  logic                         out_clear_screen,
  input  logic                         out_redraw,
  input  logic                         out_stop_song,
  input  logic                         out_start_play,
  input  logic                         out_play_held,
  output int unsigned                  mismatches,
  output int unsigned                  pending,
  output int unsigned                  checked
);
  import cwm_pkg::*;

  logic [SEG_W-1:0]    last_seg;
  logic                wheel_armed;
  logic [ITEM_W-1:0]   item_idx;
  logic [SCREEN_W-1:0] screen_mode;
  logic [VOL_W-1:0]    vol_level;
  held_t               held;

  result_t  screen_updates_q[$];
  item_in_t smp;
  result_t  want;
  result_t  got;

  task automatic step_menu(input item_in_t s, output result_t res);
    int   pos;
    logic now_hi;
    logic now_lo;
    logic was_hi;
    logic was_lo;
    res = '0;
    pos = int'(item_idx);

    if (s.menu_btn && !held.menu) begin
      res.clear_screen = 1'b1;
      if (screen_mode == SCR_LIST) begin
        screen_mode = SCR_HOME;
        pos = 0;
        res.redraw = 1'b1;
      end else if (screen_mode == SCR_PLAYING) begin
        screen_mode = SCR_LIST;
        pos = 0;
        res.redraw = 1'b1;
        res.stop_song = 1'b1;
      end
    end
    held.menu = s.menu_btn;

    if (s.ff_btn) begin
      res.redraw = 1'b1;
      if (!held.ff) begin
        res.volume_changed = 1'b1;
        if (vol_level < cfg.vol_max) vol_level = vol_level + VOL_W'(1);
      end
    end
    held.ff = s.ff_btn;

    if (s.rw_btn && !held.rw) begin
      res.volume_changed = 1'b1;
      if (vol_level != '0) vol_level = vol_level - VOL_W'(1);
    end
    held.rw = s.rw_btn;

    if (s.select_btn && !held.sel) begin
      res.clear_screen = 1'b1;
      if (screen_mode == SCR_HOME) begin
        if (pos == 0) begin
          screen_mode = SCR_LIST;
          res.redraw = 1'b1;
        end
      end else if (screen_mode == SCR_LIST) begin
        screen_mode = SCR_PLAYING;
        pos = 0;
        res.redraw = 1'b1;
        res.start_play = 1'b1;
      end
    end
    held.sel = s.select_btn;

    if (s.wheel_touched && (s.wheel_segment < SEG_LIMIT)) begin
      // latch on first touch
      if (!wheel_armed) begin
        last_seg = s.wheel_segment;
        wheel_armed = 1'b1;
        res.redraw = 1'b1;
      end
      now_hi = (s.wheel_segment >= WRAP_HIGH_FIRST) && (s.wheel_segment <= WRAP_HIGH_LAST);
      now_lo = (s.wheel_segment <= WRAP_LOW_LAST);
      was_hi = (last_seg >= WRAP_HIGH_FIRST) && (last_seg <= WRAP_HIGH_LAST);
      was_lo = (last_seg <= WRAP_LOW_LAST);
      if (now_hi && was_lo) begin
        pos--;
        last_seg = s.wheel_segment;
        res.redraw = 1'b1;
      end else if (now_lo && was_hi) begin
        pos++;
        last_seg = s.wheel_segment;
        res.redraw = 1'b1;
      end else if (s.wheel_segment > last_seg) begin
        pos++;
        last_seg = s.wheel_segment;
        res.redraw = 1'b1;
      end else if (s.wheel_segment < last_seg) begin
        pos--;
        last_seg = s.wheel_segment;
        res.redraw = 1'b1;
      end
    end else begin
      wheel_armed = 1'b0;
    end

    if (pos > int'(cfg.max_item)) pos = int'(cfg.max_item);
    if (pos < 0) pos = 0;
    item_idx = ITEM_W'(pos);

    res.selected_item = item_idx;
    res.screen        = screen_mode;
    res.volume        = vol_level;
    res.play_held     = s.pp_btn;
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      last_seg    = '0;
      wheel_armed = 1'b1;
      item_idx    = '0;
      screen_mode = SCR_HOME;
      vol_level   = '0;
      held        = '0;
      mismatches  = 0;
      checked     = 0;
      screen_updates_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = {out_selected_item, out_screen, out_volume, out_volume_changed,
               out_clear_screen, out_redraw, out_stop_song, out_start_play,
               out_play_held};
        if (screen_updates_q.size() == 0) begin
          $error("result transfer with no sample outstanding");
          mismatches++;
        end else begin
          want = screen_updates_q.pop_front();
          check_field("selected_item", 32'(want.selected_item), 32'(got.selected_item));
          check_field("screen", 32'(want.screen), 32'(got.screen));
          check_field("volume", 32'(want.volume), 32'(got.volume));
          check_field("volume_changed", 32'(want.volume_changed),
                      32'(got.volume_changed));
          check_field("clear_screen", 32'(want.clear_screen), 32'(got.clear_screen));
          check_field("redraw", 32'(want.redraw), 32'(got.redraw));
          check_field("stop_song", 32'(want.stop_song), 32'(got.stop_song));
          check_field("start_play", 32'(want.start_play), 32'(got.start_play));
          check_field("play_held", 32'(want.play_held), 32'(got.play_held));
          checked++;
        end
      end
      if (in_valid && in_ready) begin
        smp = {in_wheel_touched, in_wheel_segment, in_menu_btn, in_ff_btn,
               in_rw_btn, in_pp_btn, in_select_btn};
        step_menu(smp, want);
        screen_updates_q.push_back(want);
      end
    end
    pending = screen_updates_q.size();
  end

endmodule

>>> verif/click_wheel_menu_controller_tb.sv
// ----------------------------------------------------------------------------
// click_wheel_menu_controller_tb
// Drives button and wheel samples into the click-wheel menu controller under
// several register settings and idling mixes. A directed opening covers wrap
// crossings, first touch, out-of-range segments and screen moves; random
// press/release and wheel-sweep sequences follow. The checker does the rest.
// ----------------------------------------------------------------------------
module click_wheel_menu_controller_tb;
  import cwm_pkg::*;

  localparam int   WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [ITEM_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  item_in_t in_sample;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ITEM_W-1:0]   out_selected_item;
  logic [SCREEN_W-1:0] out_screen;
  logic [VOL_W-1:0]    out_volume;
  logic out_volume_changed;
  logic out_clear_screen;
  logic out_redraw;
  logic out_stop_song;
  logic out_start_play;
  logic out_play_held;

  cfg_t        cfg_now;
  int unsigned chk_mismatches;
  int unsigned chk_pending;
  int unsigned chk_checked;

  int          send_idle_pct;
  int          recv_stall_pct;
  int unsigned samples_sent;
  int unsigned settings_used;
  int          quiet_cycles;

  logic lvl_menu, lvl_ff, lvl_rw, lvl_sel;
  bit   wheel_on;
  int   wheel_pos;
  int   wheel_dir;

  item_in_t opening_seq[] = '{
    '{1'b1, 4'd1,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 4'd2,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 4'd3,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 4'd9,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 4'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 4'd11, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 4'd4,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 4'd4,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 4'd7,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 4'd15, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 4'd12, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 4'd5,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 4'd4,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 4'd3,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 4'd2,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 4'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 4'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 4'd0,  1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
    '{1'b0, 4'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 4'd0,  1'b1, 1'b0, 1'b0, 1'b1, 1'b0},
    '{1'b0, 4'd0,  1'b1, 1'b1, 1'b0, 1'b1, 1'b0},
    '{1'b0, 4'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 4'd0,  1'b1, 1'b0, 1'b1, 1'b0, 1'b0},
    '{1'b1, 4'd6,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 4'd7,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 4'd7,  1'b0, 1'b0, 1'b0, 1'b0, 1'b1}
  };

  click_wheel_menu_controller i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_wheel_touched   (in_sample.wheel_touched),
    .in_wheel_segment   (in_sample.wheel_segment),
    .in_menu_btn        (in_sample.menu_btn),
    .in_ff_btn          (in_sample.ff_btn),
    .in_rw_btn          (in_sample.rw_btn),
    .in_pp_btn          (in_sample.pp_btn),
    .in_select_btn      (in_sample.select_btn),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_selected_item  (out_selected_item),
    .out_screen         (out_screen),
    .out_volume         (out_volume),
    .out_volume_changed (out_volume_changed),
    .out_clear_screen   (out_clear_screen),
    .out_redraw         (out_redraw),
    .out_stop_song      (out_stop_song),
    .out_start_play     (out_start_play),
    .out_play_held      (out_play_held)
  );

  cwm_menu_checker i_menu_chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_now),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_wheel_touched   (in_sample.wheel_touched),
    .in_wheel_segment   (in_sample.wheel_segment),
    .in_menu_btn        (in_sample.menu_btn),
    .in_ff_btn          (in_sample.ff_btn),
    .in_rw_btn          (in_sample.rw_btn),
    .in_pp_btn          (in_sample.pp_btn),
    .in_select_btn      (in_sample.select_btn),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_selected_item  (out_selected_item),
    .out_screen         (out_screen),
    .out_volume         (out_volume),
    .out_volume_changed (out_volume_changed),
    .out_clear_screen   (out_clear_screen),
    .out_redraw         (out_redraw),
    .out_stop_song      (out_stop_song),
    .out_start_play     (out_start_play),
    .out_play_held      (out_play_held),
    .mismatches         (chk_mismatches),
    .pending            (chk_pending),
    .checked            (chk_checked)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // hold valid across back-to-back items; drop it only for idle cycles
  task automatic send_sample(input item_in_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(negedge clk);
    while (chk_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic next_sample(input bit ramp, output item_in_t s);
    int roll;
    int delta;
    if ($urandom_range(99) < 15) lvl_menu = ~lvl_menu;
    if ($urandom_range(99) < 15) lvl_sel = ~lvl_sel;
    if (ramp) begin
      lvl_ff = ~lvl_ff;
      lvl_rw = 1'b0;
    end else begin
      if ($urandom_range(99) < 30) lvl_ff = ~lvl_ff;
      if ($urandom_range(99) < 30) lvl_rw = ~lvl_rw;
    end
    roll = $urandom_range(99);
    if (roll < 8) begin
      wheel_on = 1'b0;
      s.wheel_touched = 1'b0;
      s.wheel_segment = SEG_W'($urandom_range(15));
    end else if (roll < 13) begin
      // arbitrary segment, out-of-range codes included
      wheel_pos = $urandom_range(15);
      wheel_on = (wheel_pos < SEGMENTS);
      s.wheel_touched = 1'b1;
      s.wheel_segment = SEG_W'(wheel_pos);
    end else begin
      if (!wheel_on) begin
        wheel_pos = $urandom_range(SEGMENTS - 1);
        wheel_on = 1'b1;
      end else begin
        if ($urandom_range(19) == 0) wheel_dir = -wheel_dir;
        delta = wheel_dir * int'($urandom_range(2));
        if ($urandom_range(7) == 0) delta = -delta;
        wheel_pos = (wheel_pos + SEGMENTS + delta) % SEGMENTS;
      end
      s.wheel_touched = 1'b1;
      s.wheel_segment = SEG_W'(wheel_pos);
    end
    s.menu_btn   = lvl_menu;
    s.ff_btn     = lvl_ff;
    s.rw_btn     = lvl_rw;
    s.pp_btn     = 1'($urandom_range(1));
    s.select_btn = lvl_sel;
  endtask

  task automatic run_phase(input logic [ITEM_W-1:0] max_item,
                           input logic [VOL_W-1:0] vol_max,
                           input int idle_pct, input int stall_pct,
                           input int n_items, input bit ramp);
    item_in_t s;
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAX_ITEM;
    cfg_data  <= max_item;
    @(negedge clk);
    cfg_index <= CFG_VOL_MAX;
    cfg_data  <= ITEM_W'(vol_max);
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_now = '{max_item: max_item, vol_max: vol_max};
    settings_used++;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n_items) begin
      next_sample(ramp, s);
      send_sample(s);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_MAX_ITEM;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_sample      = '0;
    cfg_now        = '{max_item: MAX_ITEM_RST, vol_max: VOL_MAX_RST};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    samples_sent   = 0;
    settings_used  = 1;
    quiet_cycles   = 0;
    lvl_menu       = 1'b0;
    lvl_ff         = 1'b0;
    lvl_rw         = 1'b0;
    lvl_sel        = 1'b0;
    wheel_on       = 1'b0;
    wheel_pos      = 0;
    wheel_dir      = 1;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (opening_seq[i]) send_sample(opening_seq[i]);

    run_phase(8'd255, 8'd255, 0,  0,  200, 1'b0);
    run_phase(8'd7,   8'd3,   62, 0,  200, 1'b0);
    run_phase(8'd0,   8'd0,   0,  62, 150, 1'b0);
    run_phase(8'd1,   8'd128, 28, 28, 200, 1'b0);
    // climb the volume into saturation at full scale
    run_phase(8'd255, 8'd255, 0,  0,  512, 1'b1);
    run_phase(8'd255, 8'd0,   28, 28, 200, 1'b0);

    drain();

    $display("Sent %0d samples across %0d register settings; %0d results checked",
             samples_sent, settings_used, chk_checked);
    $display("Idling mixes: none, sender only, receiver only, both sides");
    if (chk_mismatches == 0 && chk_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
